@@ hw/rtl/wlg_pkg.sv @@
package wlg_pkg;

   localparam int PATCH_POSITIONS = 512;
   localparam int POS_W           = $clog2(PATCH_POSITIONS);

   localparam logic [15:0] SCALE_ONE = 16'h8000;
   localparam logic [31:0] L1_ONE    = 32'h0001_0000;

   // Loss kinds selected by the mode register.
   localparam logic [1:0] MODE_LS    = 2'd0;
   localparam logic [1:0] MODE_HUBER = 2'd1;
   localparam logic [1:0] MODE_L1    = 2'd2;

   // Register indexes on the configuration port (byte address / 4).
   localparam logic [1:0] REG_LOSS_MODE   = 2'd0;
   localparam logic [1:0] REG_HUBER_DELTA = 2'd1;
   localparam logic [1:0] REG_WEIGHT_EN   = 2'd2;

   localparam logic [30:0] HUBER_DELTA_RESET = 31'd65536;

   typedef struct packed {
      logic [1:0]  loss_mode;
      logic [30:0] huber_delta;
      logic        weighting_enable;
   } cfg_type;

endpackage

@@ hw/rtl/weighted_loss_and_gradient_unit.sv @@
// Throughput: one request per cycle while the output is not stalled; the five register
// stages are difference and table read, operand select, loss multiply, scale
// multiply and saturation. Table write requests take a slot but produce no result.
// Reset clears the valid bits and the registers (Huber delta to 1.0); the
// scale table is not cleared and holds garbage until written.
module weighted_loss_and_gradient_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [8:0] position, [40:9] target, [72:41] predicted, [88:73] weight_value,
   // [95:89] zero
   input  logic [95:0] req_tdata,
   // [0] op, [1] stage
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [31:0] loss_value
   output logic [31:0] rsp_tdata,
   // [0] saturated
   output logic [0:0]  rsp_tuser,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import wlg_pkg::*;

   cfg_type     cfg;
   logic        s1_valid, s1_ready, s1_stage;
   logic [32:0] s1_diff;
   logic [15:0] s1_scale;
   logic        s4_valid, s4_ready, s4_neg;
   logic [47:0] s4_mag;

   wlg_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   wlg_front u_front (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_tvalid),
      .in_ready     (req_tready),
      .op           (req_tuser[0]),
      .stage        (req_tuser[1]),
      .position     (req_tdata[POS_W-1:0]),
      .target       (req_tdata[40:9]),
      .predicted    (req_tdata[72:41]),
      .weight_value (req_tdata[88:73]),
      .s1_valid     (s1_valid),
      .s1_ready     (s1_ready),
      .s1_stage     (s1_stage),
      .s1_diff      (s1_diff),
      .s1_scale     (s1_scale)
   );

   wlg_core u_core (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .s1_valid (s1_valid),
      .s1_ready (s1_ready),
      .s1_stage (s1_stage),
      .s1_diff  (s1_diff),
      .s1_scale (s1_scale),
      .s4_valid (s4_valid),
      .s4_ready (s4_ready),
      .s4_mag   (s4_mag),
      .s4_neg   (s4_neg)
   );

   wlg_out u_out (
      .clock     (clock),
      .reset     (reset),
      .s4_valid  (s4_valid),
      .s4_ready  (s4_ready),
      .s4_mag    (s4_mag),
      .s4_neg    (s4_neg),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_value (rsp_tdata),
      .out_sat   (rsp_tuser[0])
   );

endmodule

@@ hw/rtl/wlg_csr.sv @@
module wlg_csr (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [3:0]        csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready,
   output wlg_pkg::cfg_type  cfg
);
   import wlg_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic    wr_en;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (csr_paddr[3:2])
            REG_LOSS_MODE:   cfg_in.loss_mode        = csr_pwdata[1:0];
            REG_HUBER_DELTA: cfg_in.huber_delta      = csr_pwdata[30:0];
            REG_WEIGHT_EN:   cfg_in.weighting_enable = csr_pwdata[0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.loss_mode        <= MODE_LS;
         cfg_ff.huber_delta      <= HUBER_DELTA_RESET;
         cfg_ff.weighting_enable <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         REG_LOSS_MODE:   csr_prdata = {30'd0, cfg_ff.loss_mode};
         REG_HUBER_DELTA: csr_prdata = {1'b0, cfg_ff.huber_delta};
         REG_WEIGHT_EN:   csr_prdata = {31'd0, cfg_ff.weighting_enable};
         default:         csr_prdata = 32'd0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

@@ hw/rtl/wlg_front.sv @@
module wlg_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  logic                      op,
   input  logic                      stage,
   input  logic [wlg_pkg::POS_W-1:0] position,
   input  logic [31:0]               target,
   input  logic [31:0]               predicted,
   input  logic [15:0]               weight_value,
   output logic                      s1_valid,
   input  logic                      s1_ready,
   output logic                      s1_stage,
   output logic [32:0]               s1_diff,
   output logic [15:0]               s1_scale
);
   import wlg_pkg::*;

   logic [15:0] scale_mem [PATCH_POSITIONS];
   logic        valid_ff, valid_in;
   logic        stage_ff;
   logic [32:0] diff_ff;
   logic [15:0] scale_ff;
   logic        accept;

   assign in_ready = !valid_ff || s1_ready;
   assign accept   = in_valid && in_ready;
   // Table writes are absorbed here and never reach the later stages.
   assign valid_in = in_ready ? (in_valid && !op) : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && op) begin
         scale_mem[position] <= weight_value;
      end
      if (accept) begin
         scale_ff <= scale_mem[position];
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         stage_ff <= stage;
         diff_ff  <= {target[31], target} - {predicted[31], predicted};
      end
   end

   assign s1_valid = valid_ff;
   assign s1_stage = stage_ff;
   assign s1_diff  = diff_ff;
   assign s1_scale = scale_ff;

endmodule

@@ hw/rtl/wlg_core.sv @@
module wlg_core (
   input  logic             clock,
   input  logic             reset,
   input  wlg_pkg::cfg_type cfg,
   input  logic             s1_valid,
   output logic             s1_ready,
   input  logic             s1_stage,
   input  logic [32:0]      s1_diff,
   input  logic [15:0]      s1_scale,
   output logic             s4_valid,
   input  logic             s4_ready,
   output logic [47:0]      s4_mag,
   output logic             s4_neg
);
   import wlg_pkg::*;

   // Stage 2: operand selection.
   logic        v2_ff, v2_in, r2;
   logic        use_mul2_ff, use_mul_in;
   logic [31:0] a2_ff, a_in;
   logic [32:0] b2_ff, b_in;
   logic [31:0] direct2_ff, direct_in;
   logic        neg2_ff, neg_in;
   logic [15:0] scale2_ff, scale_in;
   // Stage 3: loss magnitude.
   logic        v3_ff, v3_in, r3;
   logic [46:0] mag3_ff, mag3_in;
   logic        neg3_ff;
   logic [15:0] scale3_ff;
   logic [64:0] prod3;
   // Stage 4: scaled magnitude.
   logic        v4_ff, v4_in, r4;
   logic [47:0] m4_ff;
   logic        neg4_ff;
   logic [62:0] prod4;

   logic [32:0] abs_full;
   logic [31:0] ad;
   logic        d_pos;
   logic        huber_small;
   logic [32:0] huber_lin;

   assign r4       = !v4_ff || s4_ready;
   assign r3       = !v3_ff || r4;
   assign r2       = !v2_ff || r3;
   assign s1_ready = r2;

   assign v2_in = r2 ? s1_valid : v2_ff;
   assign v3_in = r3 ? v2_ff : v3_ff;
   assign v4_in = r4 ? v3_ff : v4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         v4_ff <= v4_in;
      end
   end

   assign abs_full    = s1_diff[32] ? (33'd0 - s1_diff) : s1_diff;
   assign ad          = abs_full[31:0];
   assign d_pos       = !s1_diff[32] && (s1_diff != 33'd0);
   assign huber_small = {1'b0, cfg.huber_delta} >= ad;
   // Only used when the delta is below |d|, so the difference stays positive.
   assign huber_lin   = {ad, 1'b0} - {2'b00, cfg.huber_delta};

   always_comb begin
      use_mul_in = 1'b0;
      a_in       = ad;
      b_in       = {1'b0, ad};
      direct_in  = 32'd0;
      neg_in     = 1'b0;
      case (cfg.loss_mode)
         MODE_LS: begin
            use_mul_in = !s1_stage;
            direct_in  = ad;
            neg_in     = s1_stage && d_pos;
         end
         MODE_HUBER: begin
            use_mul_in = !s1_stage;
            neg_in     = s1_stage && d_pos;
            if (huber_small) begin
               direct_in = ad;
            end else begin
               a_in      = {1'b0, cfg.huber_delta};
               b_in      = huber_lin;
               direct_in = {1'b0, cfg.huber_delta};
            end
         end
         MODE_L1: begin
            direct_in = s1_stage ? L1_ONE : ad;
            neg_in    = s1_stage && d_pos;
         end
         default: begin
            direct_in = 32'd0;
         end
      endcase
      scale_in = cfg.weighting_enable ? s1_scale : SCALE_ONE;
   end

   always_ff @(posedge clock) begin
      if (r2 && s1_valid) begin
         use_mul2_ff <= use_mul_in;
         a2_ff       <= a_in;
         b2_ff       <= b_in;
         direct2_ff  <= direct_in;
         neg2_ff     <= neg_in;
         scale2_ff   <= scale_in;
      end
   end

   assign prod3   = {33'd0, a2_ff} * {32'd0, b2_ff};
   assign mag3_in = use_mul2_ff ? prod3[63:17] : {15'd0, direct2_ff};

   always_ff @(posedge clock) begin
      if (r3 && v2_ff) begin
         mag3_ff   <= mag3_in;
         neg3_ff   <= neg2_ff;
         scale3_ff <= scale2_ff;
      end
   end

   assign prod4 = {16'd0, mag3_ff} * {47'd0, scale3_ff};

   always_ff @(posedge clock) begin
      if (r4 && v3_ff) begin
         m4_ff   <= prod4[62:15];
         neg4_ff <= neg3_ff;
      end
   end

   assign s4_valid = v4_ff;
   assign s4_mag   = m4_ff;
   assign s4_neg   = neg4_ff;

endmodule

@@ hw/rtl/wlg_out.sv @@
module wlg_out (
   input  logic        clock,
   input  logic        reset,
   input  logic        s4_valid,
   output logic        s4_ready,
   input  logic [47:0] s4_mag,
   input  logic        s4_neg,
   output logic        out_valid,
   input  logic        out_ready,
   output logic [31:0] out_value,
   output logic        out_sat
);

   logic        valid_ff, valid_in;
   logic [31:0] value_ff, value_in;
   logic        sat_ff, sat_in;
   logic [31:0] mag_clip;

   assign s4_ready = !valid_ff || out_ready;
   assign valid_in = s4_ready ? s4_valid : valid_ff;

   always_comb begin
      if (s4_neg) begin
         sat_in   = s4_mag > 48'h0000_8000_0000;
         mag_clip = sat_in ? 32'h8000_0000 : s4_mag[31:0];
         value_in = 32'd0 - mag_clip;
      end else begin
         sat_in   = s4_mag > 48'h0000_7FFF_FFFF;
         mag_clip = sat_in ? 32'h7FFF_FFFF : s4_mag[31:0];
         value_in = mag_clip;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s4_ready && s4_valid) begin
         value_ff <= value_in;
         sat_ff   <= sat_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_value = value_ff;
   assign out_sat   = sat_ff;

endmodule

@@ bench/tb_top.sv @@
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import wlg_pkg::*;

   localparam logic        OP_EVAL      = 1'b0;
   localparam logic        OP_WRITE     = 1'b1;
   localparam logic        STAGE_LOSS   = 1'b0;
   localparam logic        STAGE_GRAD   = 1'b1;
   localparam logic [1:0]  MODE_INVALID = 2'd3;
   localparam logic [31:0] Q_MAX        = 32'h7FFF_FFFF;
   localparam logic [31:0] Q_MIN        = 32'h8000_0000;
   localparam int          STALL_CYCLES = 400;
   localparam int          WATCHDOG_MAX = 4000;
   localparam int          SETTLE_WAIT  = 8;

   typedef struct {
      logic        op;
      logic        stage;
      logic [8:0]  position;
      logic [31:0] target;
      logic [31:0] predicted;
      logic [15:0] weight;
   } loss_request_type;

   typedef struct packed {
      logic [31:0] loss_value;
      logic        saturated;
   } loss_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid;
   logic        req_tready;
   logic [95:0] req_tdata;
   logic [1:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic [0:0]  rsp_tuser;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [3:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // Shadow copy of the block's registers and scale table.
   logic [1:0]   loss_mode_q;
   logic [30:0]  huber_delta_q;
   logic         weight_en_q;
   logic [15:0]  scale_table [0:PATCH_POSITIONS-1];
   logic         scale_written [0:PATCH_POSITIONS-1];
   int unsigned  written_positions [$];

   loss_result_type expected_results [$];

   int fail_count         = 0;
   int send_idle_pct      = 0;
   int recv_idle_pct      = 0;
   int stall_request_count = 0;
   int stall_seen_count   = 0;
   int stall_left         = 0;
   int quiet_cycles       = 0;

   weighted_loss_and_gradient_unit DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #10 clock = ~clock;

   function automatic void note_failure(string what, logic [31:0] want, logic [31:0] got);
      fail_count++;
      if (fail_count <= 10)
         $display("mismatch on %0s at %0t: expected %h, got %h", what, $realtime, want, got);
   endfunction

   // Loss or gradient of one evaluate request under the current registers.
   function automatic loss_result_type predict_loss(loss_request_type r);
      logic [33:0]     diff;
      logic [63:0]     abs_diff;
      logic [63:0]     delta;
      logic [63:0]     mag;
      logic [63:0]     scaled;
      logic [15:0]     scale;
      logic            diff_pos;
      logic            neg;
      loss_result_type res;
      diff     = {{2{r.target[31]}}, r.target} - {{2{r.predicted[31]}}, r.predicted};
      abs_diff = {30'd0, diff[33] ? -diff : diff};
      diff_pos = !diff[33] && (diff != '0);
      delta    = {33'd0, huber_delta_q};
      scale    = weight_en_q ? scale_table[r.position] : SCALE_ONE;
      mag      = '0;
      neg      = 1'b0;
      res      = '0;
      if (loss_mode_q == MODE_INVALID)
         return res;
      if (loss_mode_q == MODE_LS || (loss_mode_q == MODE_HUBER && delta >= abs_diff)) begin
         if (r.stage == STAGE_LOSS) begin
            mag = (abs_diff * abs_diff) >> 17;
         end else begin
            mag = abs_diff;
            neg = diff_pos;
         end
      end else if (loss_mode_q == MODE_HUBER) begin
         if (r.stage == STAGE_LOSS) begin
            mag = (delta * ((abs_diff << 1) - delta)) >> 17;
         end else begin
            mag = delta;
            neg = diff_pos;
         end
      end else begin
         if (r.stage == STAGE_LOSS) begin
            mag = abs_diff;
         end else begin
            mag = {32'd0, L1_ONE};
            neg = diff_pos;
         end
      end
      scaled = (mag * {48'd0, scale}) >> 15;
      if (neg) begin
         if (scaled > 64'h8000_0000) begin
            scaled        = 64'h8000_0000;
            res.saturated = 1'b1;
         end
         res.loss_value = ~scaled[31:0] + 32'd1;
      end else begin
         if (scaled > 64'h7FFF_FFFF) begin
            scaled        = 64'h7FFF_FFFF;
            res.saturated = 1'b1;
         end
         res.loss_value = scaled[31:0];
      end
      return res;
   endfunction

   function automatic loss_request_type make_eval(logic stage, logic [8:0] position,
                                                  logic [31:0] target, logic [31:0] predicted);
      loss_request_type r;
      r = '{OP_EVAL, stage, position, target, predicted, 16'($urandom)};
      return r;
   endfunction

   function automatic loss_request_type make_write(logic [8:0] position, logic [15:0] weight);
      loss_request_type r;
      r = '{OP_WRITE, 1'($urandom), position, $urandom, $urandom, weight};
      return r;
   endfunction

   function automatic loss_request_type random_request();
      loss_request_type r;
      logic [31:0]      offset;
      if ($urandom_range(99) < 12) begin
         r = make_write(9'($urandom),
                        ($urandom_range(4) == 0) ? 16'($urandom) : 16'($urandom_range(16384, 32768)));
         return r;
      end
      r = make_eval(1'($urandom), 9'($urandom), $urandom, $urandom);
      if (weight_en_q)
         r.position = 9'(written_positions[$urandom_range(written_positions.size() - 1)]);
      case ($urandom_range(9))
         0, 1, 2, 3: ;
         4, 5, 6: begin
            // Differences right around the Huber threshold.
            offset      = {1'b0, huber_delta_q} + $urandom_range(2) - 1;
            r.predicted = $urandom_range(1) ? r.target - offset : r.target + offset;
         end
         7, 8: begin
            r.target    = $signed($urandom) >>> $urandom_range(31);
            r.predicted = $signed($urandom) >>> $urandom_range(31);
         end
         default: r.predicted = r.target;
      endcase
      return r;
   endfunction

   task automatic send_request(input loss_request_type r);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {7'd0, r.weight, r.predicted, r.target, r.position};
      req_tuser  <= {r.stage, r.op};
      do @(posedge clock); while (!req_tready);
      if (r.op == OP_WRITE) begin
         scale_table[r.position] = r.weight;
         if (!scale_written[r.position]) begin
            scale_written[r.position] = 1'b1;
            written_positions.push_back(r.position);
         end
      end else begin
         expected_results.push_back(predict_loss(r));
      end
   endtask

   // Stop offering requests and let every outstanding result come back.
   task automatic drain_results();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_results.size() != 0)
         @(posedge clock);
      repeat (SETTLE_WAIT) @(posedge clock);
   endtask

   task automatic write_register(input logic [1:0] index, input logic [31:0] value);
      logic [31:0] readback_want;
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (index)
         REG_LOSS_MODE: begin
            loss_mode_q   = value[1:0];
            readback_want = {30'd0, loss_mode_q};
         end
         REG_HUBER_DELTA: begin
            huber_delta_q = value[30:0];
            readback_want = {1'b0, huber_delta_q};
         end
         default: begin
            weight_en_q   = value[0];
            readback_want = {31'd0, weight_en_q};
         end
      endcase
      @(negedge clock);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== readback_want)
         note_failure("register readback", readback_want, csr_prdata);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic set_config(input logic [1:0] mode, input logic [30:0] delta,
                             input logic wen);
      drain_results();
      write_register(REG_LOSS_MODE, {30'd0, mode});
      write_register(REG_HUBER_DELTA, {1'b0, delta});
      write_register(REG_WEIGHT_EN, {31'd0, wen});
   endtask

   task automatic randomize_config();
      logic [1:0]  mode;
      logic [30:0] delta;
      case ($urandom_range(9))
         0, 1, 2: mode = MODE_LS;
         3, 4, 5: mode = MODE_HUBER;
         6, 7, 8: mode = MODE_L1;
         default: mode = MODE_INVALID;
      endcase
      case ($urandom_range(4))
         0:       delta = '0;
         1:       delta = 31'h7FFF_FFFF;
         2:       delta = HUBER_DELTA_RESET;
         3:       delta = 31'($urandom_range(1 << 22));
         default: delta = 31'($urandom);
      endcase
      set_config(mode, delta, (written_positions.size() != 0) && ($urandom_range(1) == 1));
   endtask

   // Runs on the values left by reset.
   task automatic test_least_squares_extremes();
      send_request(make_eval(STAGE_LOSS, 9'd0, 32'd0, 32'd0));
      send_request(make_eval(STAGE_LOSS, 9'h1FF, Q_MAX, Q_MIN));
      send_request(make_eval(STAGE_GRAD, 9'h155, Q_MAX, Q_MIN));
      send_request(make_eval(STAGE_GRAD, 9'h0AA, Q_MIN, Q_MAX));
      send_request(make_eval(STAGE_LOSS, 9'd3, 32'h0001_0000, 32'hFFFF_0000));
   endtask

   task automatic test_huber_threshold();
      set_config(MODE_HUBER, HUBER_DELTA_RESET, 1'b0);
      send_request(make_eval(STAGE_LOSS, 9'd5, 32'h0001_0000, 32'd0));
      send_request(make_eval(STAGE_GRAD, 9'd5, 32'h0001_0000, 32'd0));
      send_request(make_eval(STAGE_LOSS, 9'd6, 32'h0001_0001, 32'd0));
      send_request(make_eval(STAGE_GRAD, 9'd6, 32'd0, 32'h0001_0001));
      set_config(MODE_HUBER, 31'd0, 1'b0);
      send_request(make_eval(STAGE_LOSS, 9'd7, 32'h1234_5678, 32'hFEDC_BA98));
      send_request(make_eval(STAGE_GRAD, 9'd7, 32'h0000_4000, 32'h0000_4000));
      set_config(MODE_HUBER, 31'h7FFF_FFFF, 1'b0);
      send_request(make_eval(STAGE_LOSS, 9'd8, Q_MAX, Q_MIN));
      send_request(make_eval(STAGE_GRAD, 9'd8, Q_MIN, Q_MAX));
   endtask

   task automatic test_l1_and_invalid_mode();
      set_config(MODE_L1, HUBER_DELTA_RESET, 1'b0);
      send_request(make_eval(STAGE_GRAD, 9'd9, 32'd100, 32'd99));
      send_request(make_eval(STAGE_GRAD, 9'd9, Q_MIN, Q_MIN));
      send_request(make_eval(STAGE_GRAD, 9'd9, 32'd99, 32'd100));
      send_request(make_eval(STAGE_LOSS, 9'd9, Q_MIN, Q_MAX));
      // The unused mode code must give a zero result with no saturation.
      set_config(MODE_INVALID, HUBER_DELTA_RESET, 1'b0);
      send_request(make_eval(STAGE_LOSS, 9'd9, Q_MAX, Q_MIN));
   endtask

   task automatic test_weight_table();
      send_request(make_write(9'd0, SCALE_ONE));
      send_request(make_write(9'd511, 16'h4000));
      send_request(make_write(9'd256, 16'hFFFF));
      send_request(make_write(9'd1, 16'h0000));
      set_config(MODE_LS, HUBER_DELTA_RESET, 1'b1);
      send_request(make_eval(STAGE_GRAD, 9'd256, Q_MAX, Q_MIN));
      send_request(make_eval(STAGE_LOSS, 9'd1, Q_MAX, Q_MIN));
      send_request(make_eval(STAGE_GRAD, 9'd511, 32'h0003_0000, 32'hFFFF_8000));
      send_request(make_eval(STAGE_LOSS, 9'd0, 32'h0002_0000, 32'd0));
   endtask

   // The receiver holds off long enough for the block to fill and stall its input.
   task automatic test_output_stall();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      randomize_config();
      stall_request_count++;
      repeat (60) send_request(random_request());
      drain_results();
   endtask

   task automatic test_random_traffic(input int send_pct, input int recv_pct);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      repeat (4) begin
         randomize_config();
         repeat (100) send_request(random_request());
      end
   endtask

   always @(negedge clock) begin
      if (stall_request_count != stall_seen_count) begin
         stall_seen_count <= stall_request_count;
         stall_left       <= STALL_CYCLES;
         rsp_tready       <= 1'b0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin : check_results
      loss_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_results.size() == 0) begin
            note_failure("result with no request waiting", 32'd0, rsp_tdata);
         end else begin
            want = expected_results.pop_front();
            if (rsp_tdata !== want.loss_value)
               note_failure("loss_value", want.loss_value, rsp_tdata);
            if (rsp_tuser[0] !== want.saturated)
               note_failure("saturated", {31'd0, want.saturated}, {31'd0, rsp_tuser[0]});
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_psel && csr_penable))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_MAX) begin
         $display("tb_top: FAIL");
         $finish;
      end
   end

   initial begin
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      req_tuser     = '0;
      csr_psel      = 1'b0;
      csr_penable   = 1'b0;
      csr_pwrite    = 1'b0;
      csr_paddr     = '0;
      csr_pwdata    = '0;
      loss_mode_q   = MODE_LS;
      huber_delta_q = HUBER_DELTA_RESET;
      weight_en_q   = 1'b0;
      for (int i = 0; i < PATCH_POSITIONS; i++) begin
         scale_table[i]   = '0;
         scale_written[i] = 1'b0;
      end
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_least_squares_extremes();
      test_huber_threshold();
      test_l1_and_invalid_mode();
      test_weight_table();
      test_output_stall();
      test_random_traffic(18, 58);
      test_random_traffic(58, 18);
      test_random_traffic(0, 0);

      drain_results();
      repeat (10) @(posedge clock);
      if (fail_count == 0 && expected_results.size() == 0)
         $display("tb_top: PASS");
      else
         $display("tb_top: FAIL");
      $finish;
   end

endmodule
